FILE: hdl/weighted_table_sampler_macros.svh
// Assertion macros shared by the weighted table sampler RTL
`ifndef WEIGHTED_TABLE_SAMPLER_MACROS_SVH
`define WEIGHTED_TABLE_SAMPLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define WTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/wts_pkg.sv
// Package with constants, codes and payload types of the weighted table sampler
package wts_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int COORD_BITS  = 32;
  localparam int RANDOM_BITS = 32;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CUM_W = WEIGHT_BITS + IDX_W;
  localparam int POS_W = 3 * COORD_BITS;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
    logic [WEIGHT_BITS-1:0]        weight;
    logic [RANDOM_BITS-1:0]        random_fraction;
  } wts_in_t;

  typedef struct packed {
    logic [1:0]                    status;
    logic [IDX_W-1:0]              chosen_index;
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic signed [COORD_BITS-1:0]  out_z;
  } wts_out_t;

endpackage

FILE: hdl/weighted_table_sampler.sv
// Top level of the weighted table sampler: table append and inverse-CDF sampling
//
// The block keeps a table of up to MAX_ENTRIES positions (signed Q16.16 x, y, z)
// with the running sum of their weights. A transfer with kind append stores one
// position at the next free index and extends the running sum by its weight, or by
// one when cfg_wdata has set uniform mode; it reports the new index. A transfer
// with kind sample scales random_fraction by the total weight to a target and
// binary-searches the cumulative table for the first entry whose running sum
// exceeds the target, then returns that entry's index and position. Errors: sample
// on an empty table (status 1), sample with zero total weight (status 2), append to
// a full table (status 3); error and append results carry zero coordinates.
// Positions and running sums live in two synchronous RAMs with a registered read
// port, and the search issues one cumulative read and one compare per step. One
// item is in flight at a time; a sample's duration is set by the read-then-compare
// loop over the cumulative RAM. The result sits in an output register, so the next
// item is taken while the previous result waits on out_ready. No clearing pass is
// needed after reset: the entry count bounds every read.
module weighted_table_sampler
  import wts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  input  logic    in_valid,
  output logic    in_ready,
  input  wts_in_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output wts_out_t out_data
);

`include "weighted_table_sampler_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_POS  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int PROD_W = RANDOM_BITS + CUM_W;

  // Control and bookkeeping
  logic [2:0]             state_r,   state_nxt;
  logic                   uniform_r, uniform_nxt;
  logic [CNT_W-1:0]       cnt_r,     cnt_nxt;
  logic [CUM_W-1:0]       total_r,   total_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Payload registers
  logic [RANDOM_BITS-1:0] rand_r,    rand_nxt;
  logic [CUM_W-1:0]       target_r,  target_nxt;
  logic [CNT_W-1:0]       lo_r,      lo_nxt;
  logic [CNT_W-1:0]       hi_r,      hi_nxt;
  logic [CNT_W-1:0]       mid_r,     mid_nxt;
  wts_out_t               res_r,     res_nxt;
  wts_out_t               out_data_r, out_data_nxt;

  // RAM ports
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [IDX_W-1:0]       rd_addr;
  logic [POS_W-1:0]       pos_wdata, pos_rdata;
  logic [CUM_W-1:0]       cum_wdata, cum_rdata;

  logic                   in_xfer;
  logic [CUM_W-1:0]       add_w;
  logic [PROD_W-1:0]      prod;
  logic [CNT_W-1:0]       mid_c;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Weight added on append: one in uniform mode, else the transfer's field
  assign add_w   = uniform_r ? CUM_W'(1) : CUM_W'(in_data.weight);
  assign prod    = PROD_W'(rand_r) * PROD_W'(total_r);
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);

  // Append writes land at the accept edge; reads only start on later items,
  // so no read can meet a write to the same entry in flight.
  assign wr_en     = in_xfer && (in_data.kind == KIND_APPEND) &&
                     (cnt_r < CNT_W'(MAX_ENTRIES));
  assign wr_addr   = cnt_r[IDX_W-1:0];
  assign pos_wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z};
  assign cum_wdata = total_r + add_w;

  // Search step reads the midpoint; once the range closes, read the winner's position
  assign rd_addr   = (lo_r < hi_r) ? mid_c[IDX_W-1:0] : lo_r[IDX_W-1:0];

  wts_ram #(.WIDTH(POS_W), .DEPTH(MAX_ENTRIES)) u_pos_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (pos_wdata),
    .raddr (rd_addr),
    .rdata (pos_rdata)
  );

  wts_ram #(.WIDTH(CUM_W), .DEPTH(MAX_ENTRIES)) u_cum_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (cum_wdata),
    .raddr (rd_addr),
    .rdata (cum_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    uniform_nxt   = uniform_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    rand_nxt      = rand_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      uniform_nxt = cfg_wdata;
    end

    // Drop the output once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt = '0;
          if (in_data.kind == KIND_APPEND) begin
            if (cnt_r < CNT_W'(MAX_ENTRIES)) begin
              res_nxt.status       = ST_OK;
              res_nxt.chosen_index = cnt_r[IDX_W-1:0];
              total_nxt            = cum_wdata;
              cnt_nxt              = cnt_r + CNT_W'(1);
            end else begin
              res_nxt.status = ST_FULL;
            end
            state_nxt = S_DONE;
          end else if (cnt_r == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_DONE;
          end else if (total_r == '0) begin
            res_nxt.status = ST_ZERO;
            state_nxt      = S_DONE;
          end else begin
            rand_nxt  = in_data.random_fraction;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // target = floor(r * total / 2^RANDOM_BITS)
        target_nxt = prod[RANDOM_BITS +: CUM_W];
        lo_nxt     = '0;
        hi_nxt     = cnt_r;
        state_nxt  = S_RD;
      end
      S_RD: begin
        // Address goes out this cycle; data returns next cycle
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_POS;
        end
      end
      S_CMP: begin
        if (cum_rdata > target_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + CNT_W'(1);
        end
        state_nxt = S_RD;
      end
      S_POS: begin
        res_nxt.status       = ST_OK;
        res_nxt.chosen_index = lo_r[IDX_W-1:0];
        res_nxt.out_x        = pos_rdata[2*COORD_BITS +: COORD_BITS];
        res_nxt.out_y        = pos_rdata[COORD_BITS +: COORD_BITS];
        res_nxt.out_z        = pos_rdata[0 +: COORD_BITS];
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      uniform_r   <= 1'b0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      uniform_r   <= uniform_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rand_r     <= rand_nxt;
    target_r   <= target_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table never grows past its capacity
  `WTS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_ENTRIES), "entry count overflow")
  // Search range stays ordered and inside the written entries
  `WTS_ASSERT_IMPL(a_search_range, state_r == S_RD || state_r == S_CMP, lo_r <= hi_r && hi_r <= cnt_r, "search range broken")
  // An accepted transfer closes the input until its result is produced
  `WTS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item accepted while busy")
  // A staged result with a free output register shows up next cycle
  `WTS_ASSERT_NEXT(a_deliver, state_r == S_DONE && (!out_valid_r || out_ready), out_valid_r && in_ready, "result not delivered")

endmodule

FILE: hdl/wts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port
module wts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
